// File: hdl/i2c_master_bit_sequencer_assert.svh
// assertion macros for the i2c master bit sequencer
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c sequencer check failed");
`define I2CBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c sequencer check failed");
`else
`define I2CBS_ASSERT_SAME(label, clk, rst, ante, cons)
`define I2CBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/i2cbs_pkg.sv
// types, command codes and small helper functions of the i2c bit sequencer
// no dependencies
package i2cbs_pkg;

   typedef logic [2:0] mode_type;

   localparam mode_type CMD_NONE     = 3'd0;
   localparam mode_type CMD_START    = 3'd1;
   localparam mode_type CMD_STOP     = 3'd2;
   localparam mode_type CMD_WRITE    = 3'd3;
   localparam mode_type CMD_READ     = 3'd4;
   localparam mode_type CMD_SEND_ACK = 3'd5;
   localparam mode_type CMD_RECV_ACK = 3'd6;

   localparam logic [7:0] MSB_MASK = 8'h80;

   typedef struct packed {
      logic       scl_we;
      logic       scl_val;
      logic       sda_we;
      logic       sda_val;
      logic       rx_we;
      logic [7:0] rx_mask;
      logic       ack_we;
   } action_type;

   function automatic logic [4:0] seq_length(input mode_type cmd);
      logic [4:0] len;
      unique case (cmd)
         CMD_START:    len = 5'd4;
         CMD_STOP:     len = 5'd3;
         CMD_WRITE:    len = 5'd24;
         CMD_READ:     len = 5'd25;
         CMD_SEND_ACK: len = 5'd3;
         CMD_RECV_ACK: len = 5'd4;
         default:      len = 5'd0;
      endcase
      return len;
   endfunction

   // quotient by three, exact for values below 32
   function automatic logic [3:0] div3(input logic [4:0] v);
      logic [8:0] p;
      p = 9'(v) * 9'd11;
      return p[8:5];
   endfunction

   function automatic logic [1:0] mod3(input logic [4:0] v);
      logic [3:0] q;
      logic [4:0] r;
      q = div3(v);
      r = v - {q, 1'b0} - {1'b0, q};
      return r[1:0];
   endfunction

endpackage

// File: hdl/i2cbs_action_decode.sv
// decodes the pin action for one command and action index
// depends on i2cbs_pkg
module i2cbs_action_decode (
   input  i2cbs_pkg::mode_type   cmd,
   input  logic [4:0]            idx,
   input  logic [7:0]            tx_shift,
   input  logic                  ack_out,
   output i2cbs_pkg::action_type act
);
   import i2cbs_pkg::*;

   logic [4:0] rd_idx;
   logic [2:0] wr_bit;
   logic [1:0] wr_phase;
   logic [2:0] rd_bit;
   logic [1:0] rd_phase;

   assign rd_idx   = idx - 5'd1;
   assign wr_bit   = 3'(div3(idx));
   assign wr_phase = mod3(idx);
   assign rd_bit   = 3'(div3(rd_idx));
   assign rd_phase = mod3(rd_idx);

   always_comb begin
      act = '0;
      unique case (cmd)
         CMD_START: begin
            case (idx)
               5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
               5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
               5'd2:    begin act.sda_we = 1'b1; act.sda_val = 1'b0; end
               default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
            endcase
         end
         CMD_STOP: begin
            case (idx)
               5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b0; end
               5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
               default: begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
            endcase
         end
         CMD_WRITE: begin
            case (wr_phase)
               2'd0: begin
                  act.sda_we  = 1'b1;
                  act.sda_val = tx_shift[3'd7 - wr_bit];
               end
               2'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
               default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
            endcase
         end
         CMD_READ: begin
            if (idx == 5'd0) begin
               act.sda_we  = 1'b1;
               act.sda_val = 1'b1;
            end else begin
               case (rd_phase)
                  2'd0: begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                  2'd1: begin
                     act.rx_we   = 1'b1;
                     act.rx_mask = MSB_MASK >> rd_bit;
                  end
                  default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
               endcase
            end
         end
         CMD_SEND_ACK: begin
            case (idx)
               5'd0:    begin act.sda_we = 1'b1; act.sda_val = ack_out; end
               5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
               default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
            endcase
         end
         CMD_RECV_ACK: begin
            case (idx)
               5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
               5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
               5'd2:    act.ack_we = 1'b1;
               default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
            endcase
         end
         default: act = '0;
      endcase
   end

endmodule

// File: hdl/i2c_master_bit_sequencer.sv
// Byte-level I2C master stepped by one timebase tick per request. Every request
// is taken in the cycle it is offered unless the result register is full and
// stalled, so the block sustains one tick per clock; the result of a tick
// appears in the result register in the cycle after acceptance. The pin levels,
// busy/done flags and received data are computed by a single combinational
// pass over the sequencer state and the request; only that one result
// register stands between the two channels. csr_write_data sets how many
// ticks each pin action is held (zero acts as one) and may only be written
// while no command runs.
// depends on i2cbs_pkg, i2cbs_action_decode and i2c_master_bit_sequencer_assert.svh
`include "i2c_master_bit_sequencer_assert.svh"

module i2c_master_bit_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2cbs_pkg::mode_type  req_mode,
   input  logic [7:0]           req_tx_byte,
   input  logic                 req_ack_out,
   input  logic                 req_sda_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_scl_level,
   output logic                 rsp_sda_level,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [7:0]           rsp_rx_byte,
   output logic                 rsp_rx_ack,
   input  logic                 csr_write_en,
   input  logic [15:0]          csr_write_data
);
   import i2cbs_pkg::*;

   logic [15:0] hold_ff;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   mode_type    cmd_ff, cmd_in;
   logic [4:0]  idx_ff, idx_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic        ack_ff, ack_in;

   logic        rsp_valid_ff;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic        accept;
   logic        cmd_start;
   mode_type    cmd_eff;
   logic [4:0]  idx_eff;
   logic [15:0] tick_eff;
   logic [15:0] tick_inc;
   logic [15:0] hold;
   logic [4:0]  idx_inc;
   action_type  act;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign hold      = (hold_ff == 16'd0) ? 16'd1 : hold_ff;

   assign cmd_start = (cmd_ff == CMD_NONE) && (req_mode != CMD_NONE) && (req_mode <= CMD_RECV_ACK);
   assign cmd_eff   = cmd_start ? req_mode : cmd_ff;
   assign idx_eff   = cmd_start ? 5'd0 : idx_ff;
   assign tick_eff  = cmd_start ? 16'd0 : tick_ff;

   i2cbs_action_decode u_decode (
      .cmd      (cmd_eff),
      .idx      (idx_eff),
      .tx_shift (tx_in),
      .ack_out  (req_ack_out),
      .act      (act)
   );

   always_comb begin
      tx_in    = (cmd_start && req_mode == CMD_WRITE) ? req_tx_byte : tx_ff;
      rx_in    = (cmd_start && req_mode == CMD_READ) ? 8'd0 : rx_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      cmd_in   = cmd_eff;
      idx_in   = idx_eff;
      tick_in  = tick_eff;
      busy_in  = 1'b0;
      done_in  = 1'b0;
      tick_inc = tick_eff + 16'd1;
      idx_inc  = idx_eff + 5'd1;
      if (cmd_eff != CMD_NONE) begin
         busy_in = 1'b1;
         if (tick_eff == 16'd0) begin
            if (act.scl_we) scl_in = act.scl_val;
            if (act.sda_we) sda_in = act.sda_val;
            if (act.rx_we && req_sda_in) rx_in = rx_in | act.rx_mask;
            if (act.ack_we) ack_in = req_sda_in;
         end
         tick_in = tick_inc;
         if (tick_inc >= hold || tick_inc == 16'd0) begin
            tick_in = 16'd0;
            idx_in  = idx_inc;
            if (idx_inc >= seq_length(cmd_eff)) begin
               done_in = 1'b1;
               cmd_in  = CMD_NONE;
               idx_in  = 5'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= 16'd10;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         cmd_ff       <= CMD_NONE;
         idx_ff       <= 5'd0;
         tick_ff      <= 16'd0;
         tx_ff        <= 8'd0;
         rx_ff        <= 8'd0;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            hold_ff <= csr_write_data;
         end
         if (accept) begin
            scl_ff  <= scl_in;
            sda_ff  <= sda_in;
            cmd_ff  <= cmd_in;
            idx_ff  <= idx_in;
            tick_ff <= tick_in;
            tx_ff   <= tx_in;
            rx_ff   <= rx_in;
            ack_ff  <= ack_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_rx_byte   = rx_ff;
   assign rsp_rx_ack    = ack_ff;

   // idle sequencer holds cleared counters
   `I2CBS_ASSERT_SAME(a_idle_clear, clock, reset, cmd_ff == CMD_NONE, idx_ff == 5'd0 && tick_ff == 16'd0)
   // running sequencer stays inside its action list
   `I2CBS_ASSERT_SAME(a_idx_range, clock, reset, cmd_ff != CMD_NONE, idx_ff < seq_length(cmd_ff))
   // finishing tick returns to idle
   `I2CBS_ASSERT_NEXT(a_done_idle, clock, reset, accept && done_in, cmd_ff == CMD_NONE)
   // a shown done result is also busy
   `I2CBS_ASSERT_SAME(a_done_busy, clock, reset, rsp_valid_ff && done_ff, busy_ff)

endmodule

// File: tb/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the i2c master bit sequencer: tick requests in, pin levels out
// a scoreboard class predicts every response; depends on i2cbs_pkg and the block itself
module i2c_master_bit_sequencer_tb;
   import i2cbs_pkg::*;

   localparam mode_type CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       rx_ack;
   } pin_state_type;

   class i2c_pin_scoreboard;
      logic [15:0]   hold_cfg;
      logic          scl_q, sda_q, ack_q;
      mode_type      running;
      logic [4:0]    step;
      logic [15:0]   tick_q;
      logic [7:0]    tx_q, rx_q;
      pin_state_type expected_pins[$];
      int            mismatches, unexpected, results_seen, sequences;

      function new();
         hold_cfg = 16'd10;
         scl_q = 1'b1;
         sda_q = 1'b1;
         ack_q = 1'b0;
         running = CMD_NONE;
         step = 5'd0;
         tick_q = 16'd0;
         tx_q = 8'd0;
         rx_q = 8'd0;
      endfunction

      function void set_hold(logic [15:0] v);
         hold_cfg = v;
      endfunction

      function bit idle();
         return running == CMD_NONE;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      function int actions_in(mode_type c);
         case (c)
            CMD_START:    return 4;
            CMD_STOP:     return 3;
            CMD_WRITE:    return 24;
            CMD_READ:     return 25;
            CMD_SEND_ACK: return 3;
            CMD_RECV_ACK: return 4;
            default:      return 0;
         endcase
      endfunction

      // first tick of an action: drive a pin or sample sda
      function void take_action(logic ack, logic sda_i);
         int bit_no, phase;
         case (running)
            CMD_START: begin
               case (step)
                  0: sda_q = 1'b1;
                  1: scl_q = 1'b1;
                  2: sda_q = 1'b0;
                  default: scl_q = 1'b0;
               endcase
            end
            CMD_STOP: begin
               case (step)
                  0: sda_q = 1'b0;
                  1: scl_q = 1'b1;
                  default: sda_q = 1'b1;
               endcase
            end
            CMD_WRITE: begin
               bit_no = (int'(step) / 3) % 8;
               phase = int'(step) % 3;
               if (phase == 0) sda_q = tx_q[7 - bit_no];
               else if (phase == 1) scl_q = 1'b1;
               else scl_q = 1'b0;
            end
            CMD_READ: begin
               if (step == 0) begin
                  sda_q = 1'b1;
               end else begin
                  bit_no = ((int'(step) - 1) / 3) % 8;
                  phase = (int'(step) - 1) % 3;
                  if (phase == 0) scl_q = 1'b1;
                  else if (phase == 1) begin
                     if (sda_i) rx_q[7 - bit_no] = 1'b1;
                  end else scl_q = 1'b0;
               end
            end
            CMD_SEND_ACK: begin
               case (step)
                  0: sda_q = ack;
                  1: scl_q = 1'b1;
                  default: scl_q = 1'b0;
               endcase
            end
            CMD_RECV_ACK: begin
               case (step)
                  0: sda_q = 1'b1;
                  1: scl_q = 1'b1;
                  2: ack_q = sda_i;
                  default: scl_q = 1'b0;
               endcase
            end
            default: ;
         endcase
      endfunction

      function void note_tick(mode_type m, logic [7:0] tx, logic ack, logic sda_i);
         logic [15:0]   hold;
         pin_state_type p;
         hold = (hold_cfg == 16'd0) ? 16'd1 : hold_cfg;
         p.busy = 1'b0;
         p.done = 1'b0;
         if (running == CMD_NONE && m >= CMD_START && m <= CMD_RECV_ACK) begin
            running = m;
            step = 5'd0;
            tick_q = 16'd0;
            if (m == CMD_WRITE) tx_q = tx;
            if (m == CMD_READ) rx_q = 8'd0;
            sequences++;
         end
         if (running != CMD_NONE) begin
            p.busy = 1'b1;
            if (tick_q == 16'd0) take_action(ack, sda_i);
            tick_q = tick_q + 16'd1;
            if (tick_q >= hold || tick_q == 16'd0) begin
               tick_q = 16'd0;
               step = step + 5'd1;
               if (step >= actions_in(running)) begin
                  p.done = 1'b1;
                  running = CMD_NONE;
                  step = 5'd0;
               end
            end
         end
         p.scl = scl_q;
         p.sda = sda_q;
         p.rx = rx_q;
         p.rx_ack = ack_q;
         expected_pins.push_back(p);
      endfunction

      function void report(string field, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in response %0d, %s: expected %0h, got %0h",
                     results_seen, field, want, got);
      endfunction

      function void check_pins(pin_state_type got);
         pin_state_type want;
         if (expected_pins.size() == 0) begin
            unexpected++;
            if (unexpected <= 10) $display("response with no request pending: %p", got);
            return;
         end
         want = expected_pins.pop_front();
         results_seen++;
         if (got.scl !== want.scl) report("scl_level", want.scl, got.scl);
         if (got.sda !== want.sda) report("sda_level", want.sda, got.sda);
         if (got.busy !== want.busy) report("busy_res", want.busy, got.busy);
         if (got.done !== want.done) report("done_res", want.done, got.done);
         if (got.rx !== want.rx) report("rx_byte", want.rx, got.rx);
         if (got.rx_ack !== want.rx_ack) report("rx_ack", want.rx_ack, got.rx_ack);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mode_type    req_mode = CMD_NONE;
   logic [7:0]  req_tx_byte = 8'd0;
   logic        req_ack_out = 1'b0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res, rsp_rx_ack;
   logic [7:0]  rsp_rx_byte;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = 16'd0;

   i2c_pin_scoreboard sb = new();
   mode_type          plan[$];
   bit                tx_idling = 1'b1;
   bit                rsp_idling = 1'b1;
   bit                long_phase = 1'b0;
   int                stall_left = 0;
   int                ticks_sent = 0;

   i2c_master_bit_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_tx_byte    (req_tx_byte),
      .req_ack_out    (req_ack_out),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_rx_ack     (rsp_rx_ack),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin : responder
      int r;
      if ($urandom_range(0, 399) == 0) rsp_idling = ~rsp_idling;
      if (reset || long_phase || !rsp_idling) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
         end else if (r < 95) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pins({rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res,
                        rsp_rx_byte, rsp_rx_ack});
   end

   function automatic int pick_gap();
      int r;
      if (!tx_idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly whole transactions, sometimes a stray mode
   function automatic mode_type next_command();
      int n;
      if (plan.size() == 0) begin
         if ($urandom_range(0, 99) < 80) begin
            plan.push_back(CMD_START);
            plan.push_back(CMD_WRITE);
            plan.push_back(CMD_RECV_ACK);
            n = $urandom_range(0, 2);
            repeat (n) begin
               plan.push_back(CMD_READ);
               plan.push_back(CMD_SEND_ACK);
            end
            if ($urandom_range(0, 1)) begin
               plan.push_back(CMD_WRITE);
               plan.push_back(CMD_RECV_ACK);
            end
            plan.push_back(CMD_STOP);
         end else begin
            plan.push_back(mode_type'($urandom_range(0, 7)));
         end
      end
      return plan.pop_front();
   endfunction

   function automatic logic sda_pick(int sel);
      return (sel == 2) ? 1'($urandom) : 1'(sel);
   endfunction

   task automatic send_tick(input mode_type m, input logic [7:0] tx, input logic ack,
                            input logic sda);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_tx_byte <= tx;
      req_ack_out <= ack;
      req_sda_in  <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(m, tx, ack, sda);
      ticks_sent++;
   endtask

   // busy ticks carry random modes, which the block must ignore
   task automatic pump_to_idle(input int sda_sel);
      while (!sb.idle())
         send_tick(mode_type'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                   sda_pick(sda_sel));
   endtask

   task automatic wait_for_results();
      int guard;
      guard = 0;
      while (sb.pending() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic settle();
      pump_to_idle(2);
      req_valid <= 1'b0;
      wait_for_results();
      @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_hold(v);
   endtask

   task automatic run_command(input mode_type m, input logic [7:0] tx, input logic ack,
                              input int sda_sel);
      send_tick(m, tx, ack, sda_pick(sda_sel));
      pump_to_idle(sda_sel);
   endtask

   task automatic run_random(input int count);
      mode_type m;
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 0) tx_idling = ($urandom_range(0, 3) != 0);
         m = sb.idle() ? next_command() : mode_type'($urandom_range(0, 7));
         send_tick(m, 8'($urandom), 1'($urandom), 1'($urandom));
      end
      tx_idling = 1'b1;
      settle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset hold value of ten
      run_random(200);

      write_hold(16'd1);
      run_command(CMD_NONE, 8'h00, 1'b0, 1);
      run_command(CMD_UNUSED, 8'hFF, 1'b1, 0);
      run_command(CMD_START, 8'h00, 1'b0, 2);
      run_command(CMD_WRITE, 8'hFF, 1'b0, 2);
      run_command(CMD_WRITE, 8'h00, 1'b1, 2);
      run_command(CMD_WRITE, 8'hA5, 1'b0, 2);
      run_command(CMD_RECV_ACK, 8'h00, 1'b0, 0);
      run_command(CMD_RECV_ACK, 8'h00, 1'b0, 1);
      run_command(CMD_READ, 8'h00, 1'b0, 1);
      run_command(CMD_READ, 8'hFF, 1'b1, 0);
      run_command(CMD_READ, 8'h5A, 1'b0, 2);
      run_command(CMD_SEND_ACK, 8'h00, 1'b0, 2);
      run_command(CMD_SEND_ACK, 8'h00, 1'b1, 2);
      run_command(CMD_STOP, 8'h00, 1'b0, 2);
      run_random(500);

      // zero hold acts as one
      write_hold(16'd0);
      run_random(300);
      write_hold(16'd3);
      run_random(300);
      write_hold(16'd2);
      run_random(250);

      // long hold, one short command with no gaps
      tx_idling = 1'b0;
      long_phase = 1'b1;
      write_hold(16'd25);
      run_command(CMD_STOP, 8'h00, 1'b0, 2);
      settle();
      long_phase = 1'b0;
      tx_idling = 1'b1;

      write_hold(16'd1);
      run_random(50);

      repeat (8) @(posedge clock);
      $display("ran %0d ticks and %0d command sequences over hold values 0, 1, 2, 3, 10, 25",
               ticks_sent, sb.sequences);
      $display("%0d responses checked: %0d field mismatches, %0d unexpected, %0d missing",
               sb.results_seen, sb.mismatches, sb.unexpected, sb.pending());
      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", sb.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
